### hdl/swc_pkg.sv
// Shared types and constants for the segment window clipper.
// Used by the interfaces, the front, the queue, the back and the top level.
package swc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegMinX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxX = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinY = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxY = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode = 3'd4;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   path_start;
  } point_t;

  typedef struct packed {
    coord_t seg_x0;
    coord_t seg_y0;
    coord_t seg_x1;
    coord_t seg_y1;
  } seg_t;

  // Work handed from the front to the back: a segment to clip, or a point
  // that is already known to be kept (bypass).
  typedef struct packed {
    logic   bypass;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_XREJ, BK_CUTX0, BK_CUTX1, BK_YREJ, BK_CUTY0, BK_CUTY1,
    BK_WAITDIV, BK_MUL, BK_DIV, BK_FIN, BK_OUT
  } bk_state_t;

  function automatic coord_t sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = coord_t'(v[31:0]);
    end
  endfunction

  function automatic coord_t sub_sat(input coord_t a, input coord_t b);
    logic signed [64:0] d;
    d = 65'(a) - 65'(b);
    sub_sat = sat32(d);
  endfunction

endpackage

### hdl/swc_stream_if.sv
// Valid/ready stream interface carrying one payload.
// Depends on swc_pkg for payload types.
interface swc_stream_if #(
  parameter type payload_t = swc_pkg::point_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/swc_front.sv
// Front part: accepts points, keeps the previous point, classifies each beat.
// Depends on swc_pkg.
module swc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swc_pkg::point_t   in_data,
  input  logic              draw_mode,
  input  swc_pkg::coord_t   min_x,
  input  swc_pkg::coord_t   max_x,
  input  swc_pkg::coord_t   min_y,
  input  swc_pkg::coord_t   max_y,
  output logic              q_valid,
  input  logic              q_ready,
  output swc_pkg::job_t     q_data
);
  swc_pkg::coord_t prev_x_r, prev_y_r;
  logic have_prev_r;
  logic acc, in_win, swap;

  assign in_ready = q_ready;
  assign acc = in_valid && in_ready;
  assign in_win = !(in_data.point_x < min_x || in_data.point_x > max_x ||
                    in_data.point_y < min_y || in_data.point_y > max_y);
  assign swap = in_data.point_x < prev_x_r;

  always_comb begin
    q_data.bypass = draw_mode;
    if (draw_mode) begin
      q_data.x0 = in_data.point_x;
      q_data.y0 = in_data.point_y;
      q_data.x1 = in_data.point_x;
      q_data.y1 = in_data.point_y;
      q_valid = in_valid && in_win;
    end else begin
      q_data.x0 = swap ? in_data.point_x : prev_x_r;
      q_data.y0 = swap ? in_data.point_y : prev_y_r;
      q_data.x1 = swap ? prev_x_r : in_data.point_x;
      q_data.y1 = swap ? prev_y_r : in_data.point_y;
      q_valid = in_valid && have_prev_r && !in_data.path_start;
    end
  end

  // A beat that produces no job is still taken when the queue has room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      have_prev_r <= 1'b0;
    end else if (acc) begin
      prev_x_r <= in_data.point_x;
      prev_y_r <= in_data.point_y;
      have_prev_r <= 1'b1;
    end
  end
endmodule

### hdl/swc_queue.sv
// Short job queue that decouples the front and the back.
// Depends on swc_pkg.
module swc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  swc_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output swc_pkg::job_t rd_data
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  swc_pkg::job_t mem_r [Depth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (PtrW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end
endmodule

### hdl/swc_div.sv
// Radix-2 signed divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Truncates toward zero and saturates the quotient to 32 bits. Uses swc_pkg.
module swc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  dividend,
  input  swc_pkg::coord_t     divisor,
  output logic                busy,
  output swc_pkg::coord_t     quotient
);
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] dv_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic [32:0] trial;
  logic [63:0] mag;
  logic signed [64:0] sq;

  assign busy = cnt_r != '0;
  assign trial = {rem_r[31:0], q_r[63]} - {1'b0, dv_r};
  assign mag = dividend[63] ? 64'(-dividend) : 64'(dividend);
  assign sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign quotient = swc_pkg::sat32(sq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      q_r <= mag;
      rem_r <= '0;
      dv_r <= divisor[31] ? 32'(-divisor) : 32'(divisor);
      neg_r <= dividend[63] ^ divisor[31];
      cnt_r <= 7'd64;
    end else if (busy) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

### hdl/swc_back.sv
// Back part: rejects and cuts one segment against the window, then holds
// the result for the output channel. Depends on swc_pkg and swc_div.
module swc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  swc_pkg::job_t     q_data,
  input  swc_pkg::coord_t   min_x,
  input  swc_pkg::coord_t   max_x,
  input  swc_pkg::coord_t   min_y,
  input  swc_pkg::coord_t   max_y,
  output logic              out_valid,
  input  logic              out_ready,
  output swc_pkg::seg_t     out_data
);
  swc_pkg::bk_state_t st_r, st_nxt, ret_r;
  swc_pkg::coord_t x0_r, y0_r, x1_r, y1_r;
  swc_pkg::coord_t num_r, mul_r, den_r, oth_r, edge_r;
  logic signed [63:0] prod_r;
  logic [1:0] tgt_r; // 0:y0 1:y1 2:x0 3:x1
  logic div_start, div_busy;
  swc_pkg::coord_t div_q, cut_v;
  logic setup;
  logic [1:0] s_tgt;
  swc_pkg::coord_t s_oth, s_edge, s_c, s_o0, s_o1, s_c0, s_c1;
  swc_pkg::bk_state_t s_ret;

  swc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(den_r), .busy(div_busy), .quotient(div_q)
  );

  assign cut_v = swc_pkg::sat32(65'(oth_r) + 65'(div_q));

  always_comb begin
    setup = 1'b0;
    s_tgt = 2'd0;
    s_oth = y0_r; s_edge = min_x; s_c = x0_r;
    s_o0 = y0_r; s_o1 = y1_r; s_c0 = x0_r; s_c1 = x1_r;
    s_ret = swc_pkg::BK_IDLE;
    unique case (st_r)
      swc_pkg::BK_CUTX0: begin
        setup = x0_r < min_x;
        s_ret = swc_pkg::BK_CUTX1;
      end
      swc_pkg::BK_CUTX1: begin
        setup = x1_r > max_x;
        s_tgt = 2'd1; s_oth = y1_r; s_edge = max_x; s_c = x1_r;
        s_ret = swc_pkg::BK_YREJ;
      end
      swc_pkg::BK_CUTY0: begin
        setup = (y0_r < min_y) || (y0_r > max_y);
        s_tgt = 2'd2; s_oth = x0_r; s_c = y0_r;
        s_edge = (y0_r < min_y) ? min_y : max_y;
        s_o0 = x0_r; s_o1 = x1_r; s_c0 = y0_r; s_c1 = y1_r;
        s_ret = swc_pkg::BK_CUTY1;
      end
      swc_pkg::BK_CUTY1: begin
        setup = (y1_r < min_y) || (y1_r > max_y);
        s_tgt = 2'd3; s_oth = x1_r; s_c = y1_r;
        s_edge = (y1_r < min_y) ? min_y : max_y;
        s_o0 = x0_r; s_o1 = x1_r; s_c0 = y0_r; s_c1 = y1_r;
        s_ret = swc_pkg::BK_OUT;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      swc_pkg::BK_IDLE:
        if (q_valid) st_nxt = q_data.bypass ? swc_pkg::BK_OUT : swc_pkg::BK_XREJ;
      swc_pkg::BK_XREJ:
        st_nxt = ((x0_r < min_x && x1_r < min_x) || (x0_r > max_x && x1_r > max_x))
                 ? swc_pkg::BK_IDLE : swc_pkg::BK_CUTX0;
      swc_pkg::BK_YREJ:
        st_nxt = ((y0_r < min_y && y1_r < min_y) || (y0_r > max_y && y1_r > max_y))
                 ? swc_pkg::BK_IDLE : swc_pkg::BK_CUTY0;
      swc_pkg::BK_CUTX0, swc_pkg::BK_CUTX1, swc_pkg::BK_CUTY0, swc_pkg::BK_CUTY1:
        st_nxt = setup ? swc_pkg::BK_MUL : s_ret;
      swc_pkg::BK_MUL:
        st_nxt = (den_r == '0) ? swc_pkg::BK_FIN : swc_pkg::BK_DIV;
      swc_pkg::BK_DIV: st_nxt = swc_pkg::BK_WAITDIV;
      swc_pkg::BK_WAITDIV: if (!div_busy) st_nxt = swc_pkg::BK_FIN;
      swc_pkg::BK_FIN: st_nxt = ret_r;
      swc_pkg::BK_OUT: if (out_ready) st_nxt = swc_pkg::BK_IDLE;
      default: st_nxt = swc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = st_r == swc_pkg::BK_IDLE;
    out_valid = st_r == swc_pkg::BK_OUT;
    div_start = st_r == swc_pkg::BK_DIV;
    out_data.seg_x0 = x0_r;
    out_data.seg_y0 = y0_r;
    out_data.seg_x1 = x1_r;
    out_data.seg_y1 = y1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= swc_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == swc_pkg::BK_IDLE && q_valid) begin
      x0_r <= q_data.x0; y0_r <= q_data.y0;
      x1_r <= q_data.x1; y1_r <= q_data.y1;
    end
    if (setup) begin
      tgt_r <= s_tgt; oth_r <= s_oth; edge_r <= s_edge; ret_r <= s_ret;
      num_r <= swc_pkg::sub_sat(s_edge, s_c);
      mul_r <= swc_pkg::sub_sat(s_o1, s_o0);
      den_r <= swc_pkg::sub_sat(s_c1, s_c0);
    end
    if (st_r == swc_pkg::BK_MUL) begin
      prod_r <= num_r * mul_r;
    end
    // With a zero span the other coordinate is kept; only the cut one moves.
    if (st_r == swc_pkg::BK_FIN) begin
      unique case (tgt_r)
        2'd0: begin y0_r <= (den_r == '0) ? oth_r : cut_v; x0_r <= edge_r; end
        2'd1: begin y1_r <= (den_r == '0) ? oth_r : cut_v; x1_r <= edge_r; end
        2'd2: begin x0_r <= (den_r == '0) ? oth_r : cut_v; y0_r <= edge_r; end
        2'd3: begin x1_r <= (den_r == '0) ? oth_r : cut_v; y1_r <= edge_r; end
        default: ;
      endcase
    end
  end
endmodule

### hdl/segment_window_clipper_unit.sv
// Top level of the segment window clipper.
// Depends on swc_pkg, swc_stream_if, swc_front, swc_queue and swc_back.
//
// Points arrive as beats on the in_ channel (point_x, point_y, path_start,
// signed Q16.16) and clipped segments leave as beats on the out_ channel.
// In line mode each point after the first of a path yields at most one
// segment; in point mode each point inside the window yields one beat.
// Window edges and mode are written through cfg_we/cfg_idx/cfg_data; the
// user must do so only while the block is idle, which it does not enforce.
// A front stage takes one beat a cycle while its two-entry queue has room.
// The back processes one job at a time: it rejects a segment against x,
// cuts the x ends, rejects against y, then cuts the y ends; each of up to
// four cuts multiplies, then divides on the shared one-bit-a-cycle 64-bit
// divider unless the span is zero. A point-mode beat goes straight to the
// back's output register.
// A result waits in the back's output register while the receiver stalls;
// the front keeps filling the queue meanwhile.
// Synchronous reset restores the full window, line mode, and no stored point.
module segment_window_clipper_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  swc_stream_if.sink                     in_ch,
  swc_stream_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [swc_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [swc_pkg::CoordW-1:0]     cfg_data
);
  swc_pkg::coord_t min_x_r, max_x_r, min_y_r, max_y_r;
  logic mode_r;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  swc_pkg::job_t fq_data, bq_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= 32'sh80000000;
      max_x_r <= 32'sh7fffffff;
      min_y_r <= 32'sh80000000;
      max_y_r <= 32'sh7fffffff;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        swc_pkg::RegMinX: min_x_r <= cfg_data;
        swc_pkg::RegMaxX: max_x_r <= cfg_data;
        swc_pkg::RegMinY: min_y_r <= cfg_data;
        swc_pkg::RegMaxY: max_y_r <= cfg_data;
        swc_pkg::RegMode: mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  swc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .draw_mode(mode_r), .min_x(min_x_r), .max_x(max_x_r),
    .min_y(min_y_r), .max_y(max_y_r), .q_valid(fq_valid), .q_ready(fq_ready),
    .q_data(fq_data)
  );

  swc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_data), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  swc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(bq_valid), .q_ready(bq_ready),
    .q_data(bq_data), .min_x(min_x_r), .max_x(max_x_r), .min_y(min_y_r),
    .max_y(max_y_r), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
  );
endmodule

### test/segment_window_clipper_unit_tb.sv
// Testbench for segment_window_clipper_unit: drives path points, predicts clipped segments.
// Depends on swc_pkg and swc_stream_if from the RTL.
module segment_window_clipper_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned PhaseItems = 300;

  class clip_scoreboard;
    swc_pkg::coord_t win_x_lo, win_x_hi, win_y_lo, win_y_hi;
    bit point_mode;
    swc_pkg::coord_t last_x, last_y;
    bit have_last;
    swc_pkg::seg_t pending_segs[$];
    int unsigned errors;
    int unsigned points_seen;
    int unsigned segs_seen;

    function void reset_state();
      win_x_lo = 32'sh80000000;
      win_x_hi = 32'sh7fffffff;
      win_y_lo = 32'sh80000000;
      win_y_hi = 32'sh7fffffff;
      point_mode = 1'b0;
      last_x = '0;
      last_y = '0;
      have_last = 1'b0;
      pending_segs.delete();
      errors = 0;
      points_seen = 0;
      segs_seen = 0;
    endfunction

    function void write_reg(logic [swc_pkg::CfgIdxW-1:0] idx,
                            logic [swc_pkg::CoordW-1:0] val);
      case (idx)
        swc_pkg::RegMinX: win_x_lo = swc_pkg::coord_t'(val);
        swc_pkg::RegMaxX: win_x_hi = swc_pkg::coord_t'(val);
        swc_pkg::RegMinY: win_y_lo = swc_pkg::coord_t'(val);
        swc_pkg::RegMaxY: win_y_hi = swc_pkg::coord_t'(val);
        swc_pkg::RegMode: point_mode = val[0];
        default: ;
      endcase
    endfunction

    function swc_pkg::coord_t clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return swc_pkg::coord_t'(v);
    endfunction

    // Moves one end to an edge along the line; a zero span keeps the other coordinate.
    function swc_pkg::coord_t edge_cut(swc_pkg::coord_t other, swc_pkg::coord_t edge_v,
                                       swc_pkg::coord_t c, swc_pkg::coord_t o0,
                                       swc_pkg::coord_t o1, swc_pkg::coord_t c0,
                                       swc_pkg::coord_t c1);
      swc_pkg::coord_t num, mul, den;
      longint quo;
      num = clamp32(longint'(edge_v) - longint'(c));
      mul = clamp32(longint'(o1) - longint'(o0));
      den = clamp32(longint'(c1) - longint'(c0));
      if (den == 0) return other;
      quo = (longint'(num) * longint'(mul)) / longint'(den);
      return clamp32(longint'(other) + longint'(clamp32(quo)));
    endfunction

    function void note_point(swc_pkg::point_t p);
      swc_pkg::coord_t x0, y0, x1, y1, tmp;
      bit had;
      swc_pkg::seg_t s;
      points_seen++;
      had = have_last;
      x0 = last_x; y0 = last_y; x1 = p.point_x; y1 = p.point_y;
      last_x = p.point_x;
      last_y = p.point_y;
      have_last = 1'b1;
      if (point_mode) begin
        if (p.point_x < win_x_lo || p.point_x > win_x_hi ||
            p.point_y < win_y_lo || p.point_y > win_y_hi) return;
        s = '{p.point_x, p.point_y, p.point_x, p.point_y};
        pending_segs.push_back(s);
        return;
      end
      if (p.path_start || !had) return;
      if (x1 < x0) begin
        tmp = x0; x0 = x1; x1 = tmp;
        tmp = y0; y0 = y1; y1 = tmp;
      end
      if (x0 < win_x_lo && x1 < win_x_lo) return;
      if (x0 > win_x_hi && x1 > win_x_hi) return;
      if (x0 < win_x_lo) begin
        y0 = edge_cut(y0, win_x_lo, x0, y0, y1, x0, x1);
        x0 = win_x_lo;
      end
      if (x1 > win_x_hi) begin
        y1 = edge_cut(y1, win_x_hi, x1, y0, y1, x0, x1);
        x1 = win_x_hi;
      end
      if (y0 < win_y_lo && y1 < win_y_lo) return;
      if (y0 > win_y_hi && y1 > win_y_hi) return;
      if (y0 < win_y_lo) begin
        x0 = edge_cut(x0, win_y_lo, y0, x0, x1, y0, y1);
        y0 = win_y_lo;
      end else if (y0 > win_y_hi) begin
        x0 = edge_cut(x0, win_y_hi, y0, x0, x1, y0, y1);
        y0 = win_y_hi;
      end
      if (y1 < win_y_lo) begin
        x1 = edge_cut(x1, win_y_lo, y1, x0, x1, y0, y1);
        y1 = win_y_lo;
      end else if (y1 > win_y_hi) begin
        x1 = edge_cut(x1, win_y_hi, y1, x0, x1, y0, y1);
        y1 = win_y_hi;
      end
      s = '{x0, y0, x1, y1};
      pending_segs.push_back(s);
    endfunction

    function void check_seg(swc_pkg::seg_t got);
      swc_pkg::seg_t want;
      segs_seen++;
      if (pending_segs.size() == 0) begin
        $display("%0t: unexpected segment x0=%0d y0=%0d x1=%0d y1=%0d", $time,
                 got.seg_x0, got.seg_y0, got.seg_x1, got.seg_y1);
        errors++;
        return;
      end
      want = pending_segs.pop_front();
      if (got.seg_x0 !== want.seg_x0) begin
        $display("%0t: seg_x0 expected %0d actual %0d", $time, want.seg_x0, got.seg_x0);
        errors++;
      end
      if (got.seg_y0 !== want.seg_y0) begin
        $display("%0t: seg_y0 expected %0d actual %0d", $time, want.seg_y0, got.seg_y0);
        errors++;
      end
      if (got.seg_x1 !== want.seg_x1) begin
        $display("%0t: seg_x1 expected %0d actual %0d", $time, want.seg_x1, got.seg_x1);
        errors++;
      end
      if (got.seg_y1 !== want.seg_y1) begin
        $display("%0t: seg_y1 expected %0d actual %0d", $time, want.seg_y1, got.seg_y1);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [swc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [swc_pkg::CoordW-1:0] cfg_data;
  bit steady;
  int unsigned quiet_cycles;
  clip_scoreboard sb;

  swc_stream_if #(.payload_t(swc_pkg::point_t)) in_ch ();
  swc_stream_if #(.payload_t(swc_pkg::seg_t)) out_ch ();

  segment_window_clipper_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: check accepted beats, stall at random, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_seg(out_ch.data);
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 10);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("segment_window_clipper_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(swc_pkg::coord_t x, swc_pkg::coord_t y, bit first);
    swc_pkg::point_t p;
    p = '{x, y, first};
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(p);
    if (!steady && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 60);
    end
  endtask

  // Lets the block finish all work before a register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_segs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [swc_pkg::CfgIdxW-1:0] idx,
                           logic [swc_pkg::CoordW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_window(swc_pkg::coord_t xl, swc_pkg::coord_t xh,
                            swc_pkg::coord_t yl, swc_pkg::coord_t yh, bit pts);
    drain();
    write_reg(swc_pkg::RegMinX, xl);
    write_reg(swc_pkg::RegMaxX, xh);
    write_reg(swc_pkg::RegMinY, yl);
    write_reg(swc_pkg::RegMaxY, yh);
    write_reg(swc_pkg::RegMode, {31'd0, pts});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates cluster around the window edges, with some drawn from the full range.
  function automatic swc_pkg::coord_t near_coord(swc_pkg::coord_t lo, swc_pkg::coord_t hi);
    longint base;
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return swc_pkg::coord_t'($urandom);
    base = sel < 6 ? longint'(lo) : longint'(hi);
    return sb.clamp32(base + longint'($signed($urandom) >>> $urandom_range(31, 8)));
  endfunction

  task automatic random_phase(swc_pkg::coord_t xl, swc_pkg::coord_t xh,
                              swc_pkg::coord_t yl, swc_pkg::coord_t yh, bit pts);
    set_window(xl, xh, yl, yh, pts);
    repeat (PhaseItems) begin
      send_point(near_coord(xl, xh), near_coord(yl, yh), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    swc_pkg::coord_t lo, hi;
    sb = new();
    sb.reset_state();
    steady = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = swc_pkg::RegMinX;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full window after reset: extremes pass unclipped; path starts give nothing.
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh7fffffff, 32'sh80000000, 1'b0);
    send_point(32'sh00000000, 32'sh00000000, 1'b1);
    send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 1'b0);

    // Small window: cuts on each edge, descending and ascending, rejections.
    set_window(-32'sh00640000, 32'sh00640000, -32'sh00320000, 32'sh00320000, 1'b0);
    send_point(-32'sh01000000, -32'sh01000000, 1'b1);
    send_point(32'sh01000000, 32'sh01000000, 1'b0);
    send_point(-32'sh01000000, -32'sh00010000, 1'b0);
    send_point(-32'sh02000000, 32'sh00000000, 1'b0);
    send_point(32'sh02000000, 32'sh00000000, 1'b0);
    send_point(32'sh03000000, 32'sh00100000, 1'b0);
    send_point(32'sh00000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh00000000, 32'sh80000000, 1'b0);
    send_point(32'sh00100000, 32'sh00100000, 1'b0);
    send_point(32'sh00100000, 32'sh00100000, 1'b0);

    // Point mode keeps the stored point; edges count as inside.
    set_window(-32'sh00640000, 32'sh00640000, -32'sh00320000, 32'sh00320000, 1'b1);
    send_point(32'sh00640000, -32'sh00320000, 1'b0);
    send_point(32'sh00640001, 32'sh00000000, 1'b0);
    send_point(32'sh00000000, 32'sh00320001, 1'b1);
    set_window(-32'sh00640000, 32'sh00640000, -32'sh00320000, 32'sh00320000, 1'b0);
    send_point(-32'sh00100000, 32'sh00100000, 1'b0);

    // Inverted window.
    set_window(32'sh00640000, -32'sh00640000, 32'sh00320000, -32'sh00320000, 1'b0);
    send_point(32'sh00000000, 32'sh00000000, 1'b0);
    send_point(32'sh01000000, 32'sh01000000, 1'b0);
    send_point(-32'sh01000000, 32'sh00000000, 1'b0);

    random_phase(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    random_phase(-32'sh00640000, 32'sh00640000, -32'sh00320000, 32'sh00320000, 1'b0);
    steady = 1'b1;
    random_phase(-32'sh10000000, 32'sh20000000, -32'sh30000000, 32'sh08000000, 1'b0);
    steady = 1'b0;
    random_phase(32'sh00500000, -32'sh00500000, -32'sh00200000, 32'sh00400000, 1'b0);
    random_phase(-32'sh00640000, 32'sh00640000, -32'sh00320000, 32'sh00320000, 1'b1);
    lo = swc_pkg::coord_t'($urandom);
    hi = swc_pkg::coord_t'($urandom);
    random_phase(lo, hi, swc_pkg::coord_t'($urandom), swc_pkg::coord_t'($urandom),
                 $urandom_range(1));

    drain();
    $display("Covered %0d points over directed cases and six window settings", sb.points_seen);
    $display("(full, small, offset, inverted, point mode, random); %0d segments checked.",
             sb.segs_seen);
    if (sb.errors == 0 && sb.pending_segs.size() == 0) begin
      $display("segment_window_clipper_unit_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d segments never arrived", sb.errors, sb.pending_segs.size());
      $display("segment_window_clipper_unit_tb: FAIL");
    end
    $finish;
  end
endmodule

### segment_window_clipper_unit.f
hdl/swc_pkg.sv
hdl/swc_stream_if.sv
hdl/swc_front.sv
hdl/swc_queue.sv
hdl/swc_div.sv
hdl/swc_back.sv
hdl/segment_window_clipper_unit.sv
test/segment_window_clipper_unit_tb.sv
